/* rtl/tct_pkg.sv */
// Shared types, codes and helpers for the terminal cursor tracker.
// Used by every module of the block; depends on nothing else.
package tct_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned COORD_W = 8;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned TAB_W   = 5;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Wide enough for any saturation limit plus a few bits of headroom.
  localparam int unsigned CLAMP_W = 17;

  // Tab round-up dividend: column plus tab width minus one.
  localparam int unsigned TABX_W = COORD_W + 1;

  // Short queue between the classifier and the executor.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request types.
  localparam logic [REQ_W-1:0] REQ_BYTE    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SAVE    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RESTORE = 2'd3;

  // Control bytes that move the cursor.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LE_MODE   = 2'd3;

  // Line-ending modes; the unused code behaves as plain LF.
  localparam logic [MODE_W-1:0] LE_LF   = 2'd0;
  localparam logic [MODE_W-1:0] LE_CR   = 2'd1;
  localparam logic [MODE_W-1:0] LE_CRLF = 2'd2;

  localparam logic [COORD_W-1:0] COORD_ONE = 8'd1;

  // Classified operation carried through the queue.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_CR,
    OP_FF,
    OP_SET,
    OP_SAVE,
    OP_RESTORE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] set_row;
    logic [COORD_W-1:0] set_col;
  } cmd_t;

  // Live configuration seen by the executor.
  typedef struct packed {
    logic [COORD_W-1:0] max_cols;
    logic [COORD_W-1:0] max_rows;
    logic [TAB_W-1:0]   tab_width;
    logic [MODE_W-1:0]  le_mode;
  } cfg_t;

  // Executor sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } bk_state_t;

  // Saturate a coordinate at the given limit.
  function automatic logic [CLAMP_W-1:0] clamp_coord(logic [CLAMP_W-1:0] v,
                                                     logic [CLAMP_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

/* rtl/tct_front.sv */
// Input stage of the cursor tracker: accepts words and classifies them.
// Depends on tct_pkg; feeds tct_fifo.
module tct_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [tct_pkg::REQ_W-1:0]  in_req_type,
  input  logic [tct_pkg::CHAR_W-1:0] in_char_byte,
  input  logic [tct_pkg::COORD_W-1:0] in_set_row,
  input  logic [tct_pkg::COORD_W-1:0] in_set_col,
  input  logic                       q_full,
  output logic                       q_push,
  output tct_pkg::cmd_t              q_wdata
);
  import tct_pkg::*;

  logic vld_r;
  logic vld_nxt;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  // Hold the word while the queue is full.
  assign in_stall = vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = vld_r && !q_full;
  assign q_wdata  = cmd_r;

  // Map the request and byte onto an operation.
  always_comb begin
    cmd_nxt.set_row = in_set_row;
    cmd_nxt.set_col = in_set_col;
    cmd_nxt.op      = OP_NONE;
    unique case (in_req_type)
      REQ_BYTE: begin
        if (in_char_byte >= CH_SPACE && in_char_byte <= CH_TILDE) begin
          cmd_nxt.op = OP_PRINT;
        end else begin
          unique case (in_char_byte)
            CH_BS:   cmd_nxt.op = OP_BS;
            CH_TAB:  cmd_nxt.op = OP_TAB;
            CH_LF:   cmd_nxt.op = OP_LF;
            CH_FF:   cmd_nxt.op = OP_FF;
            CH_CR:   cmd_nxt.op = OP_CR;
            default: cmd_nxt.op = OP_NONE;
          endcase
        end
      end
      REQ_SET:     cmd_nxt.op = OP_SET;
      REQ_SAVE:    cmd_nxt.op = OP_SAVE;
      REQ_RESTORE: cmd_nxt.op = OP_RESTORE;
      default:     cmd_nxt.op = OP_NONE;
    endcase
  end

  assign vld_nxt = accept || (vld_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

/* rtl/tct_fifo.sv */
// Short command queue between the classifier and the executor.
// Depends on tct_pkg for the entry type and depth.
module tct_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tct_pkg::cmd_t wdata,
  input  logic          pop,
  output tct_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);
  import tct_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Count tracks pushes and pops taken in the same cycle.
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/tct_tabdiv.sv */
// Remainder unit for the tab round-up: two restoring steps per cycle.
// Depends on tct_pkg; used by tct_back.
module tct_tabdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tct_pkg::TABX_W-1:0] dividend,
  input  logic [tct_pkg::TAB_W-1:0]  divisor,
  output logic                       busy,
  output logic [tct_pkg::TAB_W-1:0]  rem
);
  import tct_pkg::*;

  // Dividend padded to an even number of bits, two bits retired per step.
  localparam int unsigned NUM_W     = TABX_W + (TABX_W % 2);
  localparam int unsigned DIV_STEPS = NUM_W / 2;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  num_r;
  logic [TAB_W-1:0]  rem_r;
  logic [TAB_W-1:0]  den_r;
  logic [TAB_W:0]    part1;
  logic [TAB_W:0]    part2;
  logic [TAB_W-1:0]  rem_nxt;

  assign busy = busy_r;
  assign rem  = rem_r;

  // Two compare-and-subtract steps on narrow values.
  always_comb begin
    part1 = {rem_r, num_r[NUM_W-1]};
    if (part1 >= {1'b0, den_r}) begin
      part1 = part1 - {1'b0, den_r};
    end
    part2 = {part1[TAB_W-1:0], num_r[NUM_W-2]};
    if (part2 >= {1'b0, den_r}) begin
      part2 = part2 - {1'b0, den_r};
    end
    rem_nxt = part2[TAB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= NUM_W'(dividend);
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

endmodule

/* rtl/tct_back.sv */
// Executor of the cursor tracker: holds the cursor state and result register.
// Depends on tct_pkg and tct_tabdiv; drains tct_fifo.
module tct_back #(
  parameter int unsigned MAX_COORD = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tct_pkg::cmd_t               head,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  tct_pkg::cfg_t               cfg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tct_pkg::COORD_W-1:0] out_cursor_col,
  output logic [tct_pkg::COORD_W-1:0] out_cursor_row
);
  import tct_pkg::*;

  bk_state_t          state_r;
  bk_state_t          state_nxt;
  logic [COORD_W-1:0] cur_col_r;
  logic [COORD_W-1:0] cur_row_r;
  logic [COORD_W-1:0] saved_col_r;
  logic [COORD_W-1:0] saved_row_r;
  logic [COORD_W-1:0] cur_col_nxt;
  logic [COORD_W-1:0] cur_row_nxt;
  logic [COORD_W-1:0] saved_col_nxt;
  logic [COORD_W-1:0] saved_row_nxt;
  logic               out_vld_r;
  logic               out_vld_nxt;
  logic [COORD_W-1:0] out_col_r;
  logic [COORD_W-1:0] out_row_r;
  logic [TABX_W-1:0]  tab_x_r;
  logic [TABX_W-1:0]  tab_x_nxt;

  logic               out_free;
  logic               div_start;
  logic               div_busy;
  logic [TAB_W-1:0]   div_rem;
  logic               apply_en;
  logic [TAB_W-1:0]   tab_eff;
  op_t                exec_op;

  logic [CLAMP_W-1:0] lim_w;
  logic [CLAMP_W-1:0] row_inc_w;
  logic [CLAMP_W-1:0] print_w;
  logic [CLAMP_W-1:0] tab_w;
  logic [CLAMP_W-1:0] wrap_cand;
  logic [CLAMP_W-1:0] set_row_w;
  logic [CLAMP_W-1:0] set_col_w;
  logic [COORD_W-1:0] row_adv;
  logic               wrap_hit;
  logic               lf_home;
  logic               cr_adv;

  assign out_free       = !out_vld_r || !out_stall;
  assign out_valid      = out_vld_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

  // A zero tab width behaves as one.
  assign tab_eff   = (cfg.tab_width == '0) ? TAB_W'(1) : cfg.tab_width;
  assign tab_x_nxt = TABX_W'(cur_col_r) + TABX_W'(tab_eff) - TABX_W'(1);

  tct_tabdiv u_tabdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tab_x_nxt),
    .divisor  (tab_eff),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (div_start) state_nxt = BK_DIV;
      BK_DIV:  if (!div_busy) state_nxt = BK_FIN;
      BK_FIN:  if (out_free)  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs. A tab word is taken even while the result waits,
  // since its remainder must be worked out in BK_DIV before it is applied.
  always_comb begin
    q_pop     = 1'b0;
    div_start = 1'b0;
    apply_en  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        q_pop     = !q_empty && (head.op == OP_TAB || out_free);
        div_start = q_pop && (head.op == OP_TAB);
        apply_en  = q_pop && (head.op != OP_TAB);
      end
      BK_DIV: begin
      end
      BK_FIN: begin
        apply_en = out_free;
      end
      default: begin
      end
    endcase
  end

  // Shared candidates: saturated row step, column step and tab stop.
  assign exec_op   = (state_r == BK_FIN) ? OP_TAB : head.op;
  assign lim_w     = CLAMP_W'(MAX_COORD);
  assign row_inc_w = clamp_coord(CLAMP_W'(cur_row_r) + CLAMP_W'(1), lim_w);
  assign row_adv   = (cur_row_r < cfg.max_rows) ? row_inc_w[COORD_W-1:0] : cur_row_r;
  assign print_w   = clamp_coord(CLAMP_W'(cur_col_r) + CLAMP_W'(1), lim_w);
  assign tab_w     = clamp_coord(CLAMP_W'(tab_x_r - TABX_W'(div_rem)), lim_w);
  assign wrap_cand = (exec_op == OP_TAB) ? tab_w : print_w;
  assign wrap_hit  = (wrap_cand >= CLAMP_W'(cfg.max_cols));
  assign set_row_w = clamp_coord(CLAMP_W'(head.set_row), lim_w);
  assign set_col_w = clamp_coord(CLAMP_W'(head.set_col), lim_w);

  // The unused mode code acts as plain LF.
  assign lf_home = (cfg.le_mode != LE_CR);
  assign cr_adv  = (cfg.le_mode == LE_CR) || (cfg.le_mode == LE_CRLF);

  // Cursor update for the operation being carried out.
  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    saved_col_nxt = saved_col_r;
    saved_row_nxt = saved_row_r;
    unique case (exec_op)
      OP_PRINT, OP_TAB: begin
        if (wrap_hit) begin
          cur_col_nxt = COORD_ONE;
          cur_row_nxt = row_adv;
        end else begin
          cur_col_nxt = wrap_cand[COORD_W-1:0];
        end
      end
      OP_BS: begin
        if (cur_col_r <= COORD_ONE) begin
          cur_col_nxt = cfg.max_cols;
          if (cur_row_r > COORD_ONE) begin
            cur_row_nxt = cur_row_r - COORD_ONE;
          end
        end else begin
          cur_col_nxt = cur_col_r - COORD_ONE;
        end
      end
      OP_LF: begin
        if (lf_home) begin
          cur_col_nxt = COORD_ONE;
        end
        cur_row_nxt = row_adv;
      end
      OP_CR: begin
        cur_col_nxt = COORD_ONE;
        if (cr_adv) begin
          cur_row_nxt = row_adv;
        end
      end
      OP_FF: begin
        cur_col_nxt = COORD_ONE;
        cur_row_nxt = COORD_ONE;
      end
      OP_SET: begin
        cur_row_nxt = set_row_w[COORD_W-1:0];
        cur_col_nxt = set_col_w[COORD_W-1:0];
      end
      OP_SAVE: begin
        saved_col_nxt = cur_col_r;
        saved_row_nxt = cur_row_r;
      end
      OP_RESTORE: begin
        cur_col_nxt = saved_col_r;
        cur_row_nxt = saved_row_r;
      end
      default: begin
      end
    endcase
  end

  assign out_vld_nxt = apply_en || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_vld_r   <= 1'b0;
      cur_col_r   <= COORD_ONE;
      cur_row_r   <= COORD_ONE;
      saved_col_r <= COORD_ONE;
      saved_row_r <= COORD_ONE;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (apply_en) begin
        cur_col_r   <= cur_col_nxt;
        cur_row_r   <= cur_row_nxt;
        saved_col_r <= saved_col_nxt;
        saved_row_r <= saved_row_nxt;
      end
    end
  end

  // Result register and tab dividend.
  always_ff @(posedge clk) begin
    if (apply_en) begin
      out_col_r <= cur_col_nxt;
      out_row_r <= cur_row_nxt;
    end
    if (div_start) begin
      tab_x_r <= tab_x_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !apply_en)
    else $error("result overwritten while stalled");
  a_fin_rem_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FIN) |-> !div_busy)
    else $error("tab finished before remainder ready");
  a_tab_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == BK_DIV) && div_busy)
    else $error("tab word did not start remainder unit");
`endif

endmodule

/* rtl/terminal_cursor_tracker_unit.sv */
// Top level of the terminal cursor tracker: configuration registers and
// the classifier, queue and executor. Depends on tct_pkg and all tct_ modules.
//
// Usage:
//   Input words (in_*) carry one request each: an output byte, a cursor set,
//   a cursor save or a cursor restore. A word is taken at a clock edge with
//   in_valid high and in_stall low. Every word yields exactly one result word
//   (out_cursor_col, out_cursor_row) with the cursor after that request,
//   taken at an edge with out_valid high and out_stall low.
//   A result is registered after each request passes the input register, the
//   queue and the executor. The executor retires one non-tab word per cycle
//   while out_stall is low; a tab word holds it through BK_DIV and BK_FIN, as
//   the two-bits-per-cycle remainder unit rounds the column up to a tab stop.
//   While out_stall is high the result holds; the queue and input register
//   keep absorbing three more words (four when a tab reaches the executor)
//   before in_stall rises.
//   The cfg_ channel is always ready and must only be written while idle.
//   Reset (rst_n low, synchronous) homes both cursors to column 1, row 1 and
//   loads 80 columns, 24 rows, tab width 8 and LF line endings.
module terminal_cursor_tracker_unit #(
  parameter int unsigned MAX_COORD = 255
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tct_pkg::REQ_W-1:0]      in_req_type,
  input  logic [tct_pkg::CHAR_W-1:0]     in_char_byte,
  input  logic [tct_pkg::COORD_W-1:0]    in_set_row,
  input  logic [tct_pkg::COORD_W-1:0]    in_set_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tct_pkg::COORD_W-1:0]    out_cursor_col,
  output logic [tct_pkg::COORD_W-1:0]    out_cursor_row,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tct_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic cfg_wr;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    unique case (cfg_index)
      CFG_MAX_COLS:  cfg_nxt.max_cols  = cfg_data;
      CFG_MAX_ROWS:  cfg_nxt.max_rows  = cfg_data;
      CFG_TAB_WIDTH: cfg_nxt.tab_width = cfg_data[TAB_W-1:0];
      CFG_LE_MODE:   cfg_nxt.le_mode   = cfg_data[MODE_W-1:0];
      default:       cfg_nxt = cfg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_cols  <= 8'd80;
      cfg_r.max_rows  <= 8'd24;
      cfg_r.tab_width <= 5'd8;
      cfg_r.le_mode   <= LE_LF;
    end else if (cfg_wr) begin
      cfg_r <= cfg_nxt;
    end
  end

  tct_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_char_byte (in_char_byte),
    .in_set_row   (in_set_row),
    .in_set_col   (in_set_col),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  tct_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  tct_back #(
    .MAX_COORD (MAX_COORD)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .cfg            (cfg_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for terminal_cursor_tracker_unit: random and directed
// request words, a scoreboard that predicts the cursor and checks each result.
// Depends on rtl/tct_pkg.sv and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tct_pkg::*;

  localparam int unsigned MAX_COORD    = 255;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_WORDS  = 150;
  localparam int unsigned PHASES       = 11;

  // Reserved line-ending code, expected to act as plain LF.
  localparam logic [MODE_W-1:0] LE_SPARE = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cursor_t;

  // Cursor predictor and result checker.
  class cursor_scoreboard;
    logic [COORD_W-1:0] max_cols;
    logic [COORD_W-1:0] max_rows;
    logic [TAB_W-1:0]   tab_width;
    logic [MODE_W-1:0]  le_mode;
    logic [COORD_W-1:0] cur_col;
    logic [COORD_W-1:0] cur_row;
    logic [COORD_W-1:0] saved_col;
    logic [COORD_W-1:0] saved_row;
    cursor_t            expected_cursors[$];
    int unsigned        mismatches;

    function new();
      max_cols   = 8'd80;
      max_rows   = 8'd24;
      tab_width  = 5'd8;
      le_mode    = LE_LF;
      cur_col    = COORD_ONE;
      cur_row    = COORD_ONE;
      saved_col  = COORD_ONE;
      saved_row  = COORD_ONE;
      mismatches = 0;
    endfunction

    function int unsigned saturate(int unsigned v);
      return (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    // The row moves down but stops at the last row.
    function void advance_row();
      if (cur_row < max_rows) cur_row = COORD_W'(saturate(cur_row + 1));
    endfunction

    function void wrap_column();
      if (cur_col >= max_cols) begin
        cur_col = COORD_ONE;
        advance_row();
      end
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_COLS:  max_cols = data;
        CFG_MAX_ROWS:  max_rows = data;
        CFG_TAB_WIDTH: tab_width = data[TAB_W-1:0];
        default:       le_mode = data[MODE_W-1:0];
      endcase
    endfunction

    // Apply one accepted request word and queue the cursor it should produce.
    function void note_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                               logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
      int unsigned step;
      int unsigned stop;
      step = (tab_width == 0) ? 1 : tab_width;
      case (req)
        REQ_BYTE: begin
          if (ch == CH_BS) begin
            if (cur_col <= COORD_ONE) begin
              cur_col = max_cols;
              if (cur_row > COORD_ONE) cur_row = cur_row - 1'b1;
            end else begin
              cur_col = cur_col - 1'b1;
            end
          end else if (ch == CH_TAB) begin
            stop = ((int'(cur_col) + step - 1) / step) * step;
            cur_col = COORD_W'(saturate(stop));
            wrap_column();
          end else if (ch == CH_LF) begin
            if (le_mode != LE_CR) cur_col = COORD_ONE;
            advance_row();
          end else if (ch == CH_FF) begin
            cur_col = COORD_ONE;
            cur_row = COORD_ONE;
          end else if (ch == CH_CR) begin
            cur_col = COORD_ONE;
            if (le_mode == LE_CR || le_mode == LE_CRLF) advance_row();
          end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
            cur_col = COORD_W'(saturate(cur_col + 1));
            wrap_column();
          end
        end
        REQ_SET: begin
          cur_row = COORD_W'(saturate(row));
          cur_col = COORD_W'(saturate(col));
        end
        REQ_SAVE: begin
          saved_row = cur_row;
          saved_col = cur_col;
        end
        default: begin
          cur_row = saved_row;
          cur_col = saved_col;
        end
      endcase
      expected_cursors.push_back('{col: cur_col, row: cur_row});
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_cursor(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      cursor_t want;
      if (expected_cursors.size() == 0) begin
        report_mismatch($sformatf("result col %0d row %0d with nothing expected", col, row));
      end else begin
        want = expected_cursors.pop_front();
        if (col !== want.col)
          report_mismatch($sformatf("column %0d, expected %0d", col, want.col));
        if (row !== want.row)
          report_mismatch($sformatf("row %0d, expected %0d", row, want.row));
      end
    endtask

    task check_empty();
      if (expected_cursors.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_cursors.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type;
  logic [CHAR_W-1:0]     in_char_byte;
  logic [COORD_W-1:0]    in_set_row;
  logic [COORD_W-1:0]    in_set_col;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_W-1:0]    out_cursor_col;
  logic [COORD_W-1:0]    out_cursor_row;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cursor_scoreboard sb = new();
  int unsigned cycle_count = 0;

  terminal_cursor_tracker_unit #(
    .MAX_COORD(MAX_COORD)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_char_byte  (in_char_byte),
    .in_set_row    (in_set_row),
    .in_set_col    (in_set_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that takes far longer than the slowest correct one fails.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Receiver stall pattern: free stretches, some long, broken by short stalls.
  initial begin
    int unsigned free_len;
    int unsigned stall_len;
    out_stall = 1'b0;
    forever begin
      free_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      stall_len = $urandom_range(1, 8);
      repeat (free_len) @(negedge clk) out_stall <= 1'b0;
      repeat (stall_len) @(negedge clk) out_stall <= 1'b1;
    end
  end

  // Every result word taken by the receiver is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_cursor(out_cursor_col, out_cursor_row);
  end

  // Present one request word and hold it until the block takes it.
  task automatic send_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                              logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_char_byte <= ch;
    in_set_row   <= row;
    in_set_col   <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, ch, row, col);
  endtask

  task automatic pause_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_for_results();
    pause_sender(1);
    while (sb.expected_cursors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
  endtask

  // Reconfigure only once the block has gone quiet. Spare upper data bits
  // are randomized since the narrow registers should ignore them.
  task automatic apply_config(logic [COORD_W-1:0] cols, logic [COORD_W-1:0] rows,
                              logic [TAB_W-1:0] tab, logic [MODE_W-1:0] mode);
    wait_for_results();
    write_reg(CFG_MAX_COLS, cols);
    write_reg(CFG_MAX_ROWS, rows);
    write_reg(CFG_TAB_WIDTH, {3'($urandom_range(0, 7)), tab});
    write_reg(CFG_LE_MODE, {6'($urandom_range(0, 63)), mode});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coordinate close to a configured limit, kept within the field.
  function automatic logic [COORD_W-1:0] near_limit(logic [COORD_W-1:0] lim);
    int v;
    v = int'(lim) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COORD_W'(v);
  endfunction

  // Random traffic in bursts. Mostly printable and cursor-moving bytes, with
  // cursor sets near the edges so that wraps and the bottom row are reached.
  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    logic [REQ_W-1:0]   req;
    logic [CHAR_W-1:0]  ch;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < count; i++) begin
        pick = $urandom_range(0, 99);
        req  = REQ_BYTE;
        ch   = CHAR_W'($urandom_range(0, 255));
        row  = $urandom_range(0, 1) ? near_limit(sb.max_rows) : 8'($urandom_range(0, 255));
        col  = $urandom_range(0, 1) ? near_limit(sb.max_cols) : 8'($urandom_range(0, 255));
        if (pick < 45) begin
          ch = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
        end else if (pick < 70) begin
          case ($urandom_range(0, 4))
            0:       ch = CH_BS;
            1:       ch = CH_TAB;
            2:       ch = CH_LF;
            3:       ch = CH_CR;
            default: ch = CH_FF;
          endcase
        end else if (pick < 88) begin
          req = REQ_SET;
        end else if (pick < 94) begin
          req = REQ_SAVE;
        end else if (pick < 100 && pick >= 94) begin
          req = REQ_RESTORE;
        end
        // Bytes 70..77 of the pick range keep a fully random byte.
        if (pick >= 70 && pick < 78) begin
          req = REQ_BYTE;
          ch  = CHAR_W'($urandom_range(0, 255));
        end
        send_request(req, ch, row, col);
        if (req != REQ_BYTE || ch == CH_BS || ch == CH_TAB || ch == CH_LF ||
            ch == CH_CR || ch == CH_FF || (ch >= CH_SPACE && ch <= CH_TILDE))
          sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_BYTE;
    in_char_byte = '0;
    in_set_row   = '0;
    in_set_col   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MAX_COLS;
    cfg_data     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset configuration.
    send_request(REQ_BYTE, 8'h41, '0, '0);
    send_request(REQ_BYTE, CH_SPACE, '0, '0);
    send_request(REQ_BYTE, CH_TILDE, '0, '0);
    send_request(REQ_BYTE, 8'h00, '0, '0);
    send_request(REQ_BYTE, 8'h7F, '0, '0);
    send_request(REQ_BYTE, 8'hFF, '0, '0);
    send_request(REQ_BYTE, CH_TAB, '0, '0);
    send_request(REQ_BYTE, CH_BS, '0, '0);
    send_request(REQ_BYTE, CH_LF, '0, '0);
    send_request(REQ_BYTE, CH_CR, '0, '0);
    // Backspace at column one wraps to the last column of the row above.
    send_request(REQ_BYTE, CH_BS, '0, '0);
    send_request(REQ_BYTE, CH_FF, '0, '0);
    // Cursor set to zero, then backspace and tab from column zero.
    send_request(REQ_SET, 8'h5A, '0, '0);
    send_request(REQ_BYTE, CH_BS, 8'hFF, 8'hFF);
    send_request(REQ_SET, 8'hA5, '0, '0);
    send_request(REQ_BYTE, CH_TAB, '0, '0);
    // Largest coordinates: the column saturates before the wrap test.
    send_request(REQ_SET, 8'h00, 8'hFF, 8'hFF);
    send_request(REQ_BYTE, 8'h7A, '0, '0);
    send_request(REQ_SAVE, 8'h0A, 8'h11, 8'h22);
    send_request(REQ_SET, 8'h0D, 8'd3, 8'd5);
    send_request(REQ_RESTORE, 8'h08, 8'h44, 8'h88);

    // Zero width, zero tab width and the spare line-ending code.
    apply_config(8'd0, 8'd1, 5'd0, LE_SPARE);
    send_request(REQ_BYTE, CH_FF, '0, '0);
    send_request(REQ_BYTE, 8'h30, '0, '0);
    send_request(REQ_BYTE, CH_TAB, '0, '0);
    send_request(REQ_BYTE, CH_LF, '0, '0);
    send_request(REQ_BYTE, CH_CR, '0, '0);

    // Random phases: fixed extremes first, then random settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_config(8'd80, 8'd24, 5'd8, LE_LF);
        1: apply_config(8'd1, 8'd1, 5'd1, LE_CR);
        2: apply_config(8'd255, 8'd255, 5'd16, LE_CRLF);
        3: apply_config(8'd0, 8'd5, 5'd0, LE_SPARE);
        4: apply_config(8'd12, 8'd4, 5'd3, LE_CR);
        5: apply_config(8'd255, 8'd2, 5'd31, LE_CRLF);
        default: begin
          cols = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 255))
                                             : COORD_W'($urandom_range(1, 20));
          rows = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 255))
                                             : COORD_W'($urandom_range(1, 10));
          apply_config(cols, rows, 5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
        end
      endcase
      run_random(PHASE_WORDS);
    end

    wait_for_results();
    sb.check_empty();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
